// ===== rtl/core/clc_pkg.sv =====
package clc_pkg;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // space, or tab through carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_NUL);
  endfunction

endpackage

// ===== rtl/core/clc_in_if.sv =====
interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_last;

  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink (input valid, input in_byte, input buffer_last, output ready);
endinterface

// ===== rtl/core/clc_out_if.sv =====
interface clc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       line_end;
  logic       run_last;

  modport source (output valid, output out_char, output line_end, output run_last,
                  input ready);
  modport sink (input valid, input out_char, input line_end, input run_last,
                output ready);
endinterface

// ===== rtl/core/clc_line_mem.sv =====
module clc_line_mem #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/config_line_cleaner.sv =====
// A byte that does not end a line is taken without leaving the idle state.
// A byte that ends a line starts the trailing-blank trim, which reads stored entries
// from the end (read, then check); then each kept character is read and loaded into
// the output register in turn (read, then load) through the single read port of the line
// store, and a load waits while the output stalls. No new byte is taken while a line is in work.
// Reset: synchronous, active low; clears counters and state, the line store is not cleared.
module config_line_cleaner #(
  parameter int MAX_LINE = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  clc_in_if.sink    in_chan,
  clc_out_if.source out_chan
);

  localparam int CW    = $clog2(MAX_LINE);
  localparam int DEPTH = MAX_LINE - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] CUT_AT = CW'(MAX_LINE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIM_RD,
    ST_TRIM_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t        state_r;
  logic [CW-1:0] raw_r;
  logic [CW-1:0] kept_r;
  logic          comment_r;
  logic          after_trunc_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] idx_r;
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_end_r;

  logic          in_hit;
  logic          is_nl;
  logic          mark;
  logic          swallow;
  logic          wr_en;
  logic [CW-1:0] raw_inc;
  logic [CW-1:0] kept_upd;
  logic          cut_hit;
  logic          line_done;
  logic [CW-1:0] len_m1;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          can_load;

  always_comb begin
    in_hit    = (state_r == ST_IDLE) && in_chan.valid;
    is_nl     = (in_chan.in_byte == clc_pkg::CH_NEWLINE);
    mark      = clc_pkg::is_mark(in_chan.in_byte);
    swallow   = after_trunc_r && is_nl;
    wr_en     = in_hit && !swallow && !is_nl && !comment_r && !mark;
    raw_inc   = raw_r + CW'(1);
    kept_upd  = (!is_nl && !comment_r && !mark) ? kept_r + CW'(1) : kept_r;
    cut_hit   = !is_nl && (raw_inc == CUT_AT);
    line_done = is_nl || cut_hit || in_chan.buffer_last;
    len_m1    = len_r - CW'(1);
    rd_addr   = (state_r == ST_TRIM_RD || state_r == ST_TRIM_CHK) ?
                len_m1[AW-1:0] : idx_r[AW-1:0];
    can_load  = !out_valid_r || out_chan.ready;
  end

  clc_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (kept_r[AW-1:0]),
    .wr_data (in_chan.in_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      raw_r         <= '0;
      kept_r        <= '0;
      comment_r     <= 1'b0;
      after_trunc_r <= 1'b0;
      len_r         <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (state_r == ST_EMIT_LD && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_hit) begin
            if (swallow) begin
              // newline right after a length cut is dropped
              after_trunc_r <= 1'b0;
            end else if (line_done) begin
              len_r         <= kept_upd;
              raw_r         <= '0;
              kept_r        <= '0;
              comment_r     <= 1'b0;
              after_trunc_r <= cut_hit && !in_chan.buffer_last;
              state_r       <= ST_TRIM_RD;
            end else begin
              after_trunc_r <= 1'b0;
              if (!comment_r && mark) begin
                comment_r <= 1'b1;
              end
              kept_r <= kept_upd;
              raw_r  <= raw_inc;
            end
          end
        end
        ST_TRIM_RD: begin
          if (len_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_TRIM_CHK;
          end
        end
        ST_TRIM_CHK: begin
          if (clc_pkg::is_blank(rd_data)) begin
            len_r   <= len_m1;
            state_r <= ST_TRIM_RD;
          end else begin
            idx_r   <= '0;
            state_r <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (can_load) begin
            out_char_r  <= rd_data;
            out_end_r   <= (idx_r == len_m1);
            if (idx_r == len_m1) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.line_end = out_end_r;
  assign out_chan.run_last = out_end_r;

endmodule
